// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of the bitmap run allocator.
// No dependencies; included by bra_checker.sv, which holds the concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define BRA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bitmap run allocator check failed");

// Property whose consequent must hold in the cycle after the antecedent.
`define BRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap run allocator sequence check failed");

`endif

// ===== rtl/core/bra_pkg.sv =====
// Package of the bitmap run allocator: field widths, stream packing, codes and types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bra_pkg;

  // Defaults of the top-level parameters.
  localparam int DEF_MAX_BITS  = 4096;
  localparam int DEF_WORD_BITS = 32;

  // Field widths of the stream items and of the size register.
  localparam int FUNC_W = 3;
  localparam int IDX_W  = 12;
  localparam int CNT_W  = 13;
  localparam int SIZE_W = 13;

  // Position arithmetic never gets narrower than index plus count needs.
  localparam int POS_MIN_W = 14;

  // Input tdata: index, count, value from the lowest bit up.
  localparam int IN_IDX_LSB   = 0;
  localparam int IN_CNT_LSB   = IN_IDX_LSB + IDX_W;
  localparam int IN_VAL_LSB   = IN_CNT_LSB + CNT_W;
  localparam int IN_TDATA_W   = ((IN_VAL_LSB + 1 + 7) / 8) * 8;

  // Output tdata: bit_res, found, start_res from the lowest bit up.
  localparam int OUT_BIT_LSB   = 0;
  localparam int OUT_FOUND_LSB = 1;
  localparam int OUT_START_LSB = 2;
  localparam int OUT_TDATA_W   = ((OUT_START_LSB + IDX_W + 7) / 8) * 8;

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam int REG_IDX_W  = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_TOTAL_SIZE = '0;
  localparam logic [SIZE_W-1:0]    TOTAL_SIZE_RST = SIZE_W'(4096);

  typedef enum logic [FUNC_W-1:0] {
    FN_TEST   = 3'd0,
    FN_WBIT   = 3'd1,
    FN_WRANGE = 3'd2,
    FN_CLEAR  = 3'd3,
    FN_INVERT = 3'd4,
    FN_FIND   = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/core/bra_word_scan.sv =====
// Word scanner of the bitmap run allocator: one bitmap word per call of the zero-run search.
// Depends on bra_pkg for the count width and the parameter defaults.
`timescale 1ns / 1ps

module bra_word_scan #(
  parameter int WORD_BITS = bra_pkg::DEF_WORD_BITS,
  parameter int LW        = bra_pkg::POS_MIN_W
) (
  input  logic [WORD_BITS-1:0]     word_i,
  input  logic [WORD_BITS-1:0]     vmask_i,
  input  logic [LW-1:0]            carry_i,
  input  logic [LW-1:0]            base_i,
  input  logic [bra_pkg::CNT_W-1:0] want_i,
  output logic                     hit_o,
  output logic [LW-1:0]            start_o,
  output logic [LW-1:0]            carry_o
);

  import bra_pkg::*;

  localparam int OW = $clog2(WORD_BITS);
  localparam int TW = $clog2(WORD_BITS + 1);

  logic [LW-1:0]        run_len;
  logic [LW-1:0]        need;
  logic [LW-1:0]        span_full;
  logic [OW-1:0]        span;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] dbl;
  logic [TW-1:0]        head_free;
  logic [TW-1:0]        tail_free;
  logic [OW-1:0]        hit_pos;
  logic                 pre_hit;
  logic                 in_hit;

  always_comb begin
    // A zero-length request is served like a request for one free bit.
    run_len   = (want_i == '0) ? LW'(1) : LW'(want_i);
    free_bits = ~word_i & vmask_i;

    // Free bits at the bottom of the word continue the run of earlier words.
    head_free = TW'(WORD_BITS);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!free_bits[i]) begin
        head_free = TW'(i);
      end
    end
    // Free bits at the top start the run that the next word may continue.
    tail_free = TW'(WORD_BITS);
    for (int i = 0; i < WORD_BITS; i++) begin
      if (!free_bits[i]) begin
        tail_free = TW'(WORD_BITS - 1 - i);
      end
    end

    need    = run_len - carry_i;
    pre_hit = (carry_i >= run_len) || (LW'(head_free) >= need);

    // Bit p of acc is set when the run_len bits ending at p are all free.
    // Runs of length 2^k are built by doubling and combined per bit of run_len-1.
    span_full = run_len - LW'(1);
    span      = span_full[OW-1:0];
    acc       = free_bits;
    dbl       = free_bits;
    for (int k = 0; k < OW; k++) begin
      if (span[k]) begin
        acc = dbl & (acc << (1 << k));
      end
      dbl = dbl & (dbl << (1 << k));
    end
    in_hit = (run_len <= LW'(WORD_BITS)) && (|acc);

    hit_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (acc[i]) begin
        hit_pos = OW'(i);
      end
    end

    hit_o   = pre_hit || in_hit;
    start_o = pre_hit ? (base_i - carry_i)
                      : (base_i + LW'(hit_pos) + LW'(1) - run_len);
    carry_o = (&free_bits) ? (carry_i + LW'(WORD_BITS)) : LW'(tail_free);
  end

endmodule

// ===== rtl/core/bitmap_run_allocator.sv =====
// Top level of the bitmap run allocator: bitmap memory, word sequencer, stream and APB ports.
// Depends on bra_pkg and bra_word_scan.
`timescale 1ns / 1ps

// The bitmap run allocator keeps MAX_BITS flag bits in a memory of words of WORD_BITS bits,
// of which the first total_size bits take part in test, write and search operations. Every
// input transfer carries one operation in tuser and produces exactly one output transfer.
// All work is done by a sequencer that walks the memory one word per cycle, with the read
// data registered, so a word is processed (and written back) in the cycle after its read,
// while the following word is read. The input side opens again when the result is loaded
// into the output register. A test or a bit or range write walks from word 0 up to the word
// that holds the end of its range; clear all and invert all walk all MAX_BITS/WORD_BITS
// words; the zero-run search stops in the word in which the first fitting run ends, or
// walks through all used words when no run fits. Items that walk no word (an empty range,
// an index outside the used size, a search with total_size zero, an unused operation code)
// pass straight to the result; unused codes give an all-zero result.
// The input side is not ready while an item is in work; the result then sits in an output
// register, so the next input transfer can be taken while the previous result still waits.
// After reset the block clears the memory in a pass over all MAX_BITS/WORD_BITS words before
// it accepts the first item; the APB port takes writes at all times.
// total_size is register 0 at byte address 0 and must only be written while the block is
// idle. Values above MAX_BITS act as MAX_BITS; bits beyond the used size keep their contents
// except under clear all and invert all.

module bitmap_run_allocator #(
  parameter int MAX_BITS  = bra_pkg::DEF_MAX_BITS,
  parameter int WORD_BITS = bra_pkg::DEF_WORD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: index [11:0], count [24:12], value [25], zero pad [31:26].
  input  logic [bra_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tuser: func [2:0].
  input  logic [bra_pkg::FUNC_W-1:0]        s_axis_tuser,
  // Output stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: bit_res [0], found [1], start_res [13:2], zero pad [15:14].
  output logic [bra_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bra_pkg::PADDR_W-1:0]       paddr,
  input  logic [bra_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bra_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  import bra_pkg::*;

  localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int PW        = $clog2(MAX_BITS + WORD_BITS + 1);
  localparam int LW        = (PW > POS_MIN_W) ? PW : POS_MIN_W;
  localparam int OW        = $clog2(WORD_BITS);
  localparam int SW        = OW + 1;

  localparam logic [LW-1:0] MAX_POS   = LW'(MAX_BITS);
  localparam logic [LW-1:0] WB_POS    = LW'(WORD_BITS);
  localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

  // Bits of a word at base wbase that lie below the absolute position bound.
  function automatic logic [WORD_BITS-1:0] low_ones(input logic [LW-1:0] bound,
                                                   input logic [LW-1:0] wbase);
    logic [LW-1:0]        rel;
    logic [WORD_BITS-1:0] ones;
    ones = '1;
    rel  = (bound > wbase) ? (bound - wbase) : '0;
    if (rel >= WB_POS) begin
      return ones;
    end
    return ~(ones << rel[SW-1:0]);
  endfunction

  // Control state.
  state_e           state_q, state_d;
  logic [AW-1:0]    rd_k_q, rd_k_d;
  logic [LW-1:0]    rd_base_q, rd_base_d;
  logic             iss_on_q, iss_on_d;
  logic             st_vld_q, st_vld_d;
  logic             m_tvalid_q, m_tvalid_d;
  logic [SIZE_W-1:0] total_size_q, total_size_d;

  // Item and result payload.
  func_e            op_q, op_d;
  logic             val_q, val_d;
  logic [CNT_W-1:0] want_q, want_d;
  logic [LW-1:0]    lo_q, lo_d;
  logic [LW-1:0]    hi_q, hi_d;
  logic [LW-1:0]    lim_q, lim_d;
  logic [AW-1:0]    st_k_q, st_k_d;
  logic [LW-1:0]    st_base_q, st_base_d;
  logic [LW-1:0]    carry_q, carry_d;
  logic             res_bit_q, res_bit_d;
  logic             res_found_q, res_found_d;
  logic [IDX_W-1:0] res_start_q, res_start_d;
  logic [OUT_TDATA_W-1:0] m_tdata_q, m_tdata_d;

  // Bitmap memory.
  logic [WORD_BITS-1:0] mem_q [NUM_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  // Combinational helpers.
  logic                 s_fire;
  logic                 out_free;
  logic                 cfg_write;
  logic [LW-1:0]        used;
  logic [LW-1:0]        size_ext;
  logic [IDX_W-1:0]     in_index;
  logic [CNT_W-1:0]     in_count;
  logic                 in_value;
  func_e                in_func;
  logic [LW-1:0]        idx_ext;
  logic [LW-1:0]        end_rng;
  logic [LW-1:0]        hi_rng;
  logic [LW-1:0]        hi_bit;
  logic [LW-1:0]        new_hi;
  logic [LW-1:0]        new_lim;
  logic [LW-1:0]        next_base;
  logic [WORD_BITS-1:0] rmask;
  logic [WORD_BITS-1:0] vmask;
  logic                 scan_hit;
  logic [LW-1:0]        scan_start;
  logic [LW-1:0]        scan_carry;
  logic                 find_hit;
  logic                 run_done;

  // ---------------------------------------------------------------------------
  // Configuration port: one register, no wait states.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[PADDR_W-1:2] == REG_TOTAL_SIZE);
  assign prdata    = (paddr[PADDR_W-1:2] == REG_TOTAL_SIZE) ?
                     APB_DATA_W'(total_size_q) : '0;
  assign total_size_d = cfg_write ? pwdata[SIZE_W-1:0] : total_size_q;

  assign size_ext = LW'(total_size_q);
  assign used     = (size_ext > MAX_POS) ? MAX_POS : size_ext;

  // ---------------------------------------------------------------------------
  // Input unpacking and per-item bounds.
  // ---------------------------------------------------------------------------
  assign in_index = s_axis_tdata[IN_IDX_LSB +: IDX_W];
  assign in_count = s_axis_tdata[IN_CNT_LSB +: CNT_W];
  assign in_value = s_axis_tdata[IN_VAL_LSB];
  assign in_func  = func_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_tvalid_q || m_axis_tready;

  assign idx_ext = LW'(in_index);
  assign end_rng = idx_ext + LW'(in_count);
  assign hi_rng  = (end_rng > used) ? used : end_rng;
  assign hi_bit  = ((idx_ext + LW'(1)) > used) ? used : (idx_ext + LW'(1));

  always_comb begin
    new_hi  = '0;
    new_lim = '0;
    unique case (in_func)
      FN_TEST, FN_WBIT: begin
        new_hi  = hi_bit;
        new_lim = (hi_bit > idx_ext) ? hi_bit : '0;
      end
      FN_WRANGE: begin
        new_hi  = hi_rng;
        new_lim = (hi_rng > idx_ext) ? hi_rng : '0;
      end
      FN_CLEAR, FN_INVERT: begin
        new_lim = MAX_POS;
      end
      FN_FIND: begin
        new_lim = used;
      end
      default: begin
        new_lim = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Word processing stage: masks and the scan unit of the zero-run search.
  // ---------------------------------------------------------------------------
  assign rmask = low_ones(hi_q, st_base_q) & ~low_ones(lo_q, st_base_q);
  assign vmask = low_ones(used, st_base_q);

  bra_word_scan #(
    .WORD_BITS (WORD_BITS),
    .LW        (LW)
  ) u_scan (
    .word_i  (rdata_q),
    .vmask_i (vmask),
    .carry_i (carry_q),
    .base_i  (st_base_q),
    .want_i  (want_q),
    .hit_o   (scan_hit),
    .start_o (scan_start),
    .carry_o (scan_carry)
  );

  assign find_hit  = st_vld_q && (op_q == FN_FIND) && scan_hit;
  assign run_done  = (!iss_on_q && !st_vld_q) || find_hit;
  assign next_base = rd_base_q + WB_POS;

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (rd_k_q == LAST_WORD) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_fire) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: memory write port.
  // ---------------------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = st_k_q;
    mem_wdata = rdata_q;
    if (state_q == ST_INIT) begin
      // Reset clearing pass, one word per cycle.
      mem_we    = 1'b1;
      mem_waddr = rd_k_q;
      mem_wdata = '0;
    end else if ((state_q == ST_RUN) && st_vld_q) begin
      unique case (op_q)
        FN_WBIT, FN_WRANGE: begin
          mem_we    = 1'b1;
          mem_wdata = val_q ? (rdata_q | rmask) : (rdata_q & ~rmask);
        end
        FN_CLEAR: begin
          mem_we    = 1'b1;
          mem_wdata = '0;
        end
        FN_INVERT: begin
          mem_we    = 1'b1;
          mem_wdata = ~rdata_q;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: counters, item registers and results.
  // ---------------------------------------------------------------------------
  always_comb begin
    rd_k_d      = rd_k_q;
    rd_base_d   = rd_base_q;
    iss_on_d    = iss_on_q;
    st_vld_d    = st_vld_q;
    st_k_d      = st_k_q;
    st_base_d   = st_base_q;
    op_d        = op_q;
    val_d       = val_q;
    want_d      = want_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    lim_d       = lim_q;
    carry_d     = carry_q;
    res_bit_d   = res_bit_q;
    res_found_d = res_found_q;
    res_start_d = res_start_q;

    unique case (state_q)
      ST_INIT: begin
        rd_k_d = rd_k_q + AW'(1);
      end
      ST_IDLE: begin
        if (s_fire) begin
          op_d        = in_func;
          val_d       = in_value;
          want_d      = in_count;
          lo_d        = idx_ext;
          hi_d        = new_hi;
          lim_d       = new_lim;
          rd_k_d      = '0;
          rd_base_d   = '0;
          iss_on_d    = (new_lim != '0);
          st_vld_d    = 1'b0;
          carry_d     = '0;
          res_bit_d   = 1'b0;
          res_found_d = 1'b0;
          res_start_d = '0;
        end
      end
      ST_RUN: begin
        // Issue the read of the next word while the previous one is processed.
        if (iss_on_q) begin
          rd_k_d    = rd_k_q + AW'(1);
          rd_base_d = next_base;
          iss_on_d  = (next_base < lim_q);
          st_vld_d  = 1'b1;
          st_k_d    = rd_k_q;
          st_base_d = rd_base_q;
        end else begin
          st_vld_d = 1'b0;
        end
        if (st_vld_q) begin
          if (op_q == FN_TEST) begin
            res_bit_d = res_bit_q | (|(rdata_q & rmask));
          end
          if (op_q == FN_FIND) begin
            carry_d = scan_carry;
            if (scan_hit) begin
              res_found_d = 1'b1;
              res_start_d = scan_start[IDX_W-1:0];
            end
          end
        end
        if (run_done) begin
          iss_on_d = 1'b0;
          st_vld_d = 1'b0;
        end
      end
      ST_DONE: begin
        iss_on_d = 1'b0;
        st_vld_d = 1'b0;
      end
      default: begin
        iss_on_d = 1'b0;
      end
    endcase
  end

  // Output register: loaded when the result is complete and the slot is free.
  always_comb begin
    m_tvalid_d = m_tvalid_q;
    m_tdata_d  = m_tdata_q;
    if ((state_q == ST_DONE) && out_free) begin
      m_tvalid_d                             = 1'b1;
      m_tdata_d                              = '0;
      m_tdata_d[OUT_BIT_LSB]                 = res_bit_q;
      m_tdata_d[OUT_FOUND_LSB]               = res_found_q;
      m_tdata_d[OUT_START_LSB +: IDX_W]      = res_start_q;
    end else if (m_axis_tready) begin
      m_tvalid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      rd_k_q       <= '0;
      rd_base_q    <= '0;
      iss_on_q     <= 1'b0;
      st_vld_q     <= 1'b0;
      m_tvalid_q   <= 1'b0;
      total_size_q <= TOTAL_SIZE_RST;
    end else begin
      state_q      <= state_d;
      rd_k_q       <= rd_k_d;
      rd_base_q    <= rd_base_d;
      iss_on_q     <= iss_on_d;
      st_vld_q     <= st_vld_d;
      m_tvalid_q   <= m_tvalid_d;
      total_size_q <= total_size_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    val_q       <= val_d;
    want_q      <= want_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    lim_q       <= lim_d;
    st_k_q      <= st_k_d;
    st_base_q   <= st_base_d;
    carry_q     <= carry_d;
    res_bit_q   <= res_bit_d;
    res_found_q <= res_found_d;
    res_start_q <= res_start_d;
    m_tdata_q   <= m_tdata_d;
  end

  // Bitmap memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[rd_k_q];
  end

endmodule

// ===== rtl/core/bra_checker.sv =====
// Port-level checker of the bitmap run allocator and its bind to the top level.
// Depends on bra_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bra_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bra_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  import bra_pkg::*;

  logic s_fire;
  logic out_stall;
  logic out_bit;
  logic out_found;
  logic [IDX_W-1:0] out_start;

  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_bit   = m_axis_tdata[OUT_BIT_LSB];
  assign out_found = m_axis_tdata[OUT_FOUND_LSB];
  assign out_start = m_axis_tdata[OUT_START_LSB +: IDX_W];

  // A stalled result stays offered and unchanged.
  `BRA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

  // One item in work at a time: the input side closes right after a transfer.
  `BRA_ASSERT_NEXT(a_in_closes, clk_i, rst_ni, s_fire, !s_axis_tready)

  // A failed or absent search reports start zero.
  `BRA_ASSERT(a_start_zero, clk_i, rst_ni, !(m_axis_tvalid && !out_found) || (out_start == '0))

  // Test and search results come from different operations.
  `BRA_ASSERT(a_one_kind, clk_i, rst_ni, !(m_axis_tvalid && out_bit && out_found))

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/tb.sv =====
// Self-checking testbench of the bitmap run allocator: directed and random operations.
// A small bitmap mirror class predicts every result; depends on bra_pkg and the RTL top.
`timescale 1ns / 1ps

module tb;
  import bra_pkg::*;

  localparam int MEM_BITS    = DEF_MAX_BITS;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_WAIT  = 150;

  // Operation codes that the block has no function for.
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  localparam logic [PADDR_W-1:0] SIZE_ADDR = {REG_TOTAL_SIZE, 2'b00};

  typedef struct packed {
    logic            bit_res;
    logic            found;
    logic [IDX_W-1:0] start;
  } op_result_t;

  // A run that the stimulus allocated and may free later.
  typedef struct {
    logic [IDX_W-1:0] at;
    logic [CNT_W-1:0] len;
  } span_t;

  // Mirror of the bitmap and the size register; queues the result of every accepted
  // operation and compares it with the result transfers in order.
  class bitmap_mirror;
    bit               mem [0:MEM_BITS-1];
    logic [SIZE_W-1:0] total_size;
    op_result_t       expected_q [$];
    int               mismatches;
    int               found_runs;
    int               failed_searches;

    function new();
      total_size = TOTAL_SIZE_RST;
      mismatches = 0;
      found_runs = 0;
      failed_searches = 0;
      for (int k = 0; k < MEM_BITS; k++) mem[k] = 1'b0;
    endfunction

    function int used_bits();
      return (int'(total_size) > MEM_BITS) ? MEM_BITS : int'(total_size);
    endfunction

    function bit bit_at(input int i);
      if (i >= used_bits()) return 1'b0;
      return mem[i];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // First fit: a set bit at the candidate start moves on by one, a set bit inside the
    // candidate restarts just past it, and the search gives up once the run cannot fit.
    function bit find_zero_run(input int want, output int start);
      int sz;
      int i;
      bit ok;
      sz = used_bits();
      i = 0;
      start = 0;
      while (i < sz) begin
        if (bit_at(i)) begin
          i++;
          continue;
        end
        if (i + want > sz) return 1'b0;
        ok = 1'b1;
        for (int j = i + 1; j < i + want; j++) begin
          if (bit_at(j)) begin
            ok = 1'b0;
            i = j + 1;
            break;
          end
        end
        if (ok) begin
          start = i;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function op_result_t predict_op(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] idx,
                                    input logic [CNT_W-1:0] cnt, input logic v);
      op_result_t r;
      int last;
      int s;
      r = '0;
      case (fn)
        FN_TEST: r.bit_res = bit_at(int'(idx));
        FN_WBIT: if (int'(idx) < used_bits()) mem[idx] = v;
        FN_WRANGE: begin
          last = int'(idx) + int'(cnt);
          if (last > used_bits()) last = used_bits();
          for (int k = int'(idx); k < last; k++) mem[k] = v;
        end
        FN_CLEAR: for (int k = 0; k < MEM_BITS; k++) mem[k] = 1'b0;
        FN_INVERT: for (int k = 0; k < MEM_BITS; k++) mem[k] = ~mem[k];
        FN_FIND: begin
          if (find_zero_run(int'(cnt), s)) begin
            r.found = 1'b1;
            r.start = s[IDX_W-1:0];
            found_runs++;
          end else begin
            failed_searches++;
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
      return r;
    endfunction

    function void check_reply(input logic [OUT_TDATA_W-1:0] d);
      op_result_t e;
      if (expected_q.size() == 0) begin
        $error("result transfer with no operation outstanding, tdata %h", d);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      if (d[OUT_BIT_LSB] !== e.bit_res) begin
        $error("bit_res mismatch: expected %0d, actual %0d", e.bit_res, d[OUT_BIT_LSB]);
        mismatches++;
      end
      if (d[OUT_FOUND_LSB] !== e.found) begin
        $error("found mismatch: expected %0d, actual %0d", e.found, d[OUT_FOUND_LSB]);
        mismatches++;
      end
      if (d[OUT_START_LSB +: IDX_W] !== e.start) begin
        $error("start_res mismatch: expected %0d, actual %0d", e.start,
               d[OUT_START_LSB +: IDX_W]);
        mismatches++;
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [FUNC_W-1:0]       s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_W-1:0]      paddr = '0;
  logic [APB_DATA_W-1:0]   pwdata = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;

  bitmap_mirror sb;
  span_t        live_runs [$];
  int           op_count [8];
  int           size_settings = 0;
  int           cfg_errors = 0;
  int           cycle_count = 0;
  int           rx_stall_left = 0;
  bit           rx_calm = 1'b0;

  bitmap_run_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one; none at all in calm stretches.
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(input int used);
    if (used > 0 && $urandom_range(0, 99) < 85) return IDX_W'($urandom_range(0, used - 1));
    return IDX_W'($urandom_range(0, MEM_BITS - 1));
  endfunction

  // Mostly small run lengths, as an allocator sees them, with a tail up to the field's top.
  function automatic logic [CNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 75) return CNT_W'($urandom_range(1, 16));
    if (r < 95) return CNT_W'($urandom_range(17, 256));
    return CNT_W'($urandom_range(257, 8191));
  endfunction

  // The result side stalls at random, sampled at the rising edge like every output.
  always @(negedge clk_i) begin
    if (rx_stall_left != 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 99) < 40) rx_stall_left = pick_gap(1'b0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer, with
  // tvalid still high so that a following item can go out without a gap.
  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] idx,
                           input logic [CNT_W-1:0] cnt, input logic v, input int gap,
                           output op_result_t res);
    logic [IN_TDATA_W-1:0] d;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    d = '0;
    d[IN_IDX_LSB +: IDX_W] = idx;
    d[IN_CNT_LSB +: CNT_W] = cnt;
    d[IN_VAL_LSB] = v;
    s_axis_tdata  <= d;
    s_axis_tuser  <= fn;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    res = sb.predict_op(fn, idx, cnt, v);
    op_count[fn]++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Writes the size register once the block is idle, reads it back and updates the mirror.
  task automatic set_size(input logic [SIZE_W-1:0] sz);
    logic [APB_DATA_W-1:0] got;
    wait_drained();
    repeat (4) @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SIZE_ADDR;
    pwdata  <= APB_DATA_W'(sz);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== APB_DATA_W'(sz)) begin
      $error("total_size mismatch: expected %0d, actual %0d", sz, got);
      cfg_errors++;
    end
    sb.total_size = sz;
    size_settings++;
  endtask

  task automatic run_directed();
    op_result_t res;
    set_size(13'd4096);
    send_item(FN_TEST,   12'd0,    13'd0,    1'b0, pick_gap(1'b0), res);
    send_item(FN_WBIT,   12'd0,    13'd0,    1'b1, pick_gap(1'b0), res);
    send_item(FN_WBIT,   12'd4095, 13'd0,    1'b1, pick_gap(1'b0), res);
    send_item(FN_TEST,   12'd4095, 13'd0,    1'b0, pick_gap(1'b0), res);
    // A zero-length search gives the first clear bit; a full-size one cannot fit.
    send_item(FN_FIND,   12'd0,    13'd0,    1'b0, pick_gap(1'b0), res);
    send_item(FN_FIND,   12'd0,    13'd4096, 1'b0, pick_gap(1'b0), res);
    // The first range runs far past the end and is clamped; the second is empty.
    send_item(FN_WRANGE, 12'd100,  13'd8191, 1'b1, pick_gap(1'b0), res);
    send_item(FN_WRANGE, 12'd200,  13'd0,    1'b0, pick_gap(1'b0), res);
    send_item(FN_FIND,   12'd0,    13'd50,   1'b0, pick_gap(1'b0), res);
    send_item(FN_FIND,   12'd0,    13'd100,  1'b0, pick_gap(1'b0), res);
    send_item(FN_WBIT,   12'd150,  13'd0,    1'b0, pick_gap(1'b0), res);
    send_item(FN_TEST,   12'd150,  13'd0,    1'b0, pick_gap(1'b0), res);
    send_item(FN_INVERT, 12'd0,    13'd0,    1'b0, pick_gap(1'b0), res);
    send_item(FN_FIND,   12'd0,    13'd0,    1'b0, pick_gap(1'b0), res);
    send_item(FN_CLEAR,  12'd0,    13'd0,    1'b0, pick_gap(1'b0), res);
    send_item(FN_TEST,   12'd4095, 13'd0,    1'b0, pick_gap(1'b0), res);
    send_item(FN_SPARE_6, 12'd4095, 13'd8191, 1'b1, pick_gap(1'b0), res);
    send_item(FN_SPARE_7, 12'd4095, 13'd8191, 1'b1, pick_gap(1'b0), res);
    // With no bits in use every search fails and writes are dropped.
    set_size(13'd0);
    send_item(FN_FIND,   12'd0,    13'd0,    1'b0, pick_gap(1'b0), res);
    send_item(FN_WBIT,   12'd3,    13'd0,    1'b1, pick_gap(1'b0), res);
    send_item(FN_TEST,   12'd3,    13'd0,    1'b0, pick_gap(1'b0), res);
    // A size above the capacity acts as the full store.
    set_size(13'd8191);
    send_item(FN_TEST,   12'd3,    13'd0,    1'b0, pick_gap(1'b0), res);
    send_item(FN_FIND,   12'd0,    13'd4096, 1'b0, pick_gap(1'b0), res);
    send_item(FN_FIND,   12'd0,    13'd4097, 1'b0, pick_gap(1'b0), res);
  endtask

  // Mostly allocator traffic: a search, then the found run taken, later freed again,
  // mixed with tests, stray writes, whole-store operations and spare codes.
  task automatic run_random(input int n_items, input bit calm);
    logic [FUNC_W-1:0] fn;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  cnt;
    logic              v;
    op_result_t        res;
    span_t             sp;
    bit                alloc_due;
    int                r;
    int                k;
    alloc_due = 1'b0;
    sp.at = '0;
    sp.len = '0;
    for (int n = 0; n < n_items; n++) begin
      // Hold the input side back once per phase until every result is home.
      if (n == n_items / 2) wait_drained();
      v   = 1'($urandom_range(0, 1));
      idx = pick_index(sb.used_bits());
      cnt = pick_count();
      r   = $urandom_range(0, 99);
      if (alloc_due && $urandom_range(0, 99) < 70) begin
        fn  = FN_WRANGE;
        idx = sp.at;
        cnt = sp.len;
        v   = 1'b1;
        live_runs.push_back(sp);
      end else if (r < 35) begin
        fn = FN_FIND;
      end else if (r < 50 && live_runs.size() != 0) begin
        k   = $urandom_range(0, live_runs.size() - 1);
        fn  = FN_WRANGE;
        idx = live_runs[k].at;
        cnt = live_runs[k].len;
        v   = 1'b0;
        live_runs.delete(k);
      end else if (r < 65) begin
        fn = FN_TEST;
      end else if (r < 77) begin
        fn = FN_WBIT;
      end else if (r < 91) begin
        fn = FN_WRANGE;
      end else if (r < 95) begin
        fn = FN_CLEAR;
        live_runs.delete();
      end else if (r < 98) begin
        fn = FN_INVERT;
        live_runs.delete();
      end else begin
        fn = $urandom_range(0, 1) ? FN_SPARE_7 : FN_SPARE_6;
      end
      send_item(fn, idx, cnt, v, pick_gap(calm), res);
      alloc_due = (fn == FN_FIND) && res.found;
      sp.at  = res.start;
      sp.len = cnt;
    end
  endtask

  initial begin : stimulus
    logic [SIZE_W-1:0] phase_sizes [11];
    phase_sizes = '{13'd4096, 13'd0, 13'd1, 13'd8191, 13'd33, 13'd4095, 13'd517,
                    13'd5000, 13'd4096, 13'd64, 13'd2047};
    sb = new();
    for (int k = 0; k < 8; k++) op_count[k] = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();

    // Each phase runs at one size; every third phase the sender leaves no gaps between
    // items, and every fourth the receiver never stalls.
    for (int p = 0; p < 11; p++) begin
      set_size(phase_sizes[p]);
      rx_calm = (p % 4 == 3);
      run_random(80, p % 3 == 2);
    end

    wait_drained();
    rx_calm = 1'b1;
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Covered %0d tests, %0d bit writes, %0d range writes, %0d clears, %0d inverts,",
             op_count[FN_TEST], op_count[FN_WBIT], op_count[FN_WRANGE],
             op_count[FN_CLEAR], op_count[FN_INVERT]);
    $display("%0d searches (%0d hits, %0d misses), %0d spare codes, %0d size settings.",
             op_count[FN_FIND], sb.found_runs, sb.failed_searches,
             op_count[FN_SPARE_6] + op_count[FN_SPARE_7], size_settings);
    if (sb.mismatches == 0 && cfg_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== bitmap_run_allocator.f =====
+incdir+rtl/core
rtl/core/bra_pkg.sv
rtl/core/bra_word_scan.sv
rtl/core/bitmap_run_allocator.sv
rtl/core/bra_checker.sv
bench/tb.sv
